>>> rtl/fpc_pkg.sv
// Package for the frustum plane culler: sizes, item kind codes and
// helper functions used by the sequencer; the divider uses its sizes.
// Depends on nothing.
package fpc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int FRAC_BITS   = 16;
  localparam int COEF_COUNT  = PLANE_COUNT * 4;
  localparam int DIV_W       = 32 + FRAC_BITS + 1;
  localparam int DIVCNT_W    = $clog2(DIV_W + 1);

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_BOX    = 2'd2;

  // Saturate a 33-bit signed sum to 32 bits.
  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Column component for plane p: w plus or minus x, y or z.
  function automatic logic [31:0] load_val(input logic [2:0] p, input logic [31:0] ax,
                                           input logic [31:0] ay, input logic [31:0] az,
                                           input logic [31:0] aw);
    logic [32:0] w33;
    logic [32:0] s;
    w33 = {aw[31], aw};
    case (p)
      3'd0:    s = w33 + {ax[31], ax};
      3'd1:    s = w33 - {ax[31], ax};
      3'd2:    s = w33 - {ay[31], ay};
      3'd3:    s = w33 + {ay[31], ay};
      3'd4:    s = w33 + {az[31], az};
      default: s = w33 - {az[31], az};
    endcase
    return sat33(s);
  endfunction

endpackage

>>> rtl/fpc_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Imports fpc_pkg but uses none of its contents.
module fpc_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import fpc_pkg::*;

  logic [33:0] rem;
  logic [63:0] rad;
  logic [4:0]  cnt;
  logic        running;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign rem_sh = {rem, rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rem     <= '0;
        root    <= '0;
        rad     <= radicand;
        cnt     <= '0;
      end else if (running) begin
        if (rem_sh >= trial) begin
          rem  <= 34'(rem_sh - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh[33:0];
          root <= {root[30:0], 1'b0};
        end
        rad <= {rad[61:0], 2'b00};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/fpc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fpc_pkg for the dividend width.
module fpc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fpc_pkg::DIV_W-1:0] dividend,
  input  logic [31:0]              divisor,
  output logic                     done,
  output logic [fpc_pkg::DIV_W-1:0] quotient
);
  import fpc_pkg::*;

  logic [31:0]         rem;
  logic [31:0]         dvs;
  logic [DIVCNT_W-1:0] cnt;
  logic                running;
  logic [32:0]         rs;

  assign rs = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        rem      <= '0;
        quotient <= dividend;
        dvs      <= divisor;
        cnt      <= '0;
      end else if (running) begin
        if (rs >= {1'b0, dvs}) begin
          rem      <= 32'(rs - {1'b0, dvs});
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem      <= rs[31:0];
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIVCNT_W'(DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/frustum_plane_cull.sv
// Frustum plane culler top level: sequencer, plane store and shared multiplier.
// Depends on fpc_pkg, fpc_isqrt and fpc_div.
//
// Usage: present an item with start high while busy is low; it is taken at that
// clock edge and busy rises for the whole of its processing. A load item
// (kind 0) writes one matrix column into the six planes, one plane per cycle.
// The load that completes all four columns then normalizes the planes: per
// plane 3 squaring steps, a square root and, unless the root is zero, four
// divisions. A sphere test (kind 1) walks the planes through one shared
// multiplier. A box test (kind 2) first forms its radius with three squares
// and the root, then runs the sphere pass and, if that fails, a positive-vertex
// pass. A test item's answer appears on inside_res with done high for exactly
// one cycle; the receiver cannot stall it. Kind 3 items are taken and dropped.
// Synchronous reset clears the plane store, the column mask and the sequencer.
module frustum_plane_cull (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [1:0]  column_index,
  input  logic [31:0] a_x,
  input  logic [31:0] a_y,
  input  logic [31:0] a_z,
  input  logic [31:0] a_w,
  input  logic [31:0] b_x,
  input  logic [31:0] b_y,
  input  logic [31:0] b_z,
  output logic        done,
  output logic        inside_res
);
  import fpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_NSQ_MUL, S_NSQ_ACC, S_NSQ_GO, S_NSQRT, S_NDIV, S_NDIV_WAIT,
    S_BSQ_MUL, S_BSQ_ACC, S_BSQ_GO, S_BSQRT, S_EV_D, S_EV_MUL, S_EV_ACC, S_EV_CHK
  } state_t;

  state_t state;

  logic [31:0] coeff [COEF_COUNT];
  logic [3:0]  seen;
  logic [2:0]  p;
  logic [1:0]  k;
  logic [1:0]  col;
  logic [1:0]  kind_r;
  logic        vpass;

  // Held item operands: raw corners, test centre and box side lengths.
  logic [31:0] ax, ay, az, aw, bx, by, bz;
  logic [31:0] cx, cy, cz;
  logic [32:0] sx, sy, sz;
  logic [33:0] rr;

  logic [65:0] preg;
  logic [65:0] bsum;
  logic [63:0] nsum;
  logic [63:0] acc;
  logic [31:0] len;

  logic [31:0] cur;
  logic [4:0]  cidx;
  logic [33:0] ma, mb;
  logic [67:0] prod;
  logic [32:0] coord;
  logic [32:0] side;

  logic        sq_start, sq_done;
  logic [63:0] sq_in;
  logic [31:0] sq_root;
  logic        dv_start, dv_done;
  logic [DIV_W-1:0] dv_q;
  logic [DIV_W-1:0] dv_in;
  logic [31:0] cmag;
  logic        big;
  logic [31:0] nval;
  logic        fail;
  logic [32:0] sum_x, sum_y, sum_z, dif_x, dif_y, dif_z;
  logic [63:0] term;

  assign busy = (state != S_IDLE);
  assign cidx = {p, k};
  assign cur  = coeff[cidx];

  // Coordinate for the current component: centre in the sphere pass, the
  // positive vertex in the box's second pass.
  always_comb begin
    logic [31:0] av, bv, cv;
    case (k)
      2'd0:    begin av = ax; bv = bx; cv = cx; side = sx; end
      2'd1:    begin av = ay; bv = by; cv = cy; side = sy; end
      default: begin av = az; bv = bz; cv = cz; side = sz; end
    endcase
    if (vpass) begin
      coord = cur[31] ? {av[31], av} : {bv[31], bv};
    end else begin
      coord = {cv[31], cv};
    end
  end

  // Shared multiplier operands.
  always_comb begin
    case (state)
      S_NSQ_MUL: begin ma = {{2{cur[31]}}, cur}; mb = {{2{cur[31]}}, cur}; end
      S_BSQ_MUL: begin ma = {1'b0, side};        mb = {1'b0, side};        end
      S_EV_MUL:  begin ma = {{2{cur[31]}}, cur}; mb = {coord[32], coord};  end
      default:   begin ma = '0;                  mb = '0;                  end
    endcase
  end
  assign prod = $signed(ma) * $signed(mb);

  assign term = 64'($signed(preg) >>> FRAC_BITS);
  assign fail = vpass ? acc[63] : (acc[63] || (acc == '0));

  assign sq_start = (state == S_NSQ_GO) || (state == S_BSQ_GO);
  assign sq_in    = (state == S_BSQ_GO) ? bsum[65:2] : nsum;

  assign cmag  = cur[31] ? 32'(-cur) : cur;
  assign dv_in = DIV_W'({cmag, {FRAC_BITS{1'b0}}}) + DIV_W'(len >> 1);
  assign dv_start = (state == S_NDIV);
  assign big   = |dv_q[DIV_W-1:31];
  assign nval  = cur[31] ? (big ? 32'h8000_0000 : 32'(-dv_q[31:0]))
                         : (big ? 32'h7FFF_FFFF : dv_q[31:0]);

  assign sum_x = {a_x[31], a_x} + {b_x[31], b_x};
  assign sum_y = {a_y[31], a_y} + {b_y[31], b_y};
  assign sum_z = {a_z[31], a_z} + {b_z[31], b_z};
  assign dif_x = {b_x[31], b_x} - {a_x[31], a_x};
  assign dif_y = {b_y[31], b_y} - {a_y[31], a_y};
  assign dif_z = {b_z[31], b_z} - {a_z[31], a_z};

  fpc_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root)
  );

  fpc_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_in), .divisor(len),
    .done(dv_done), .quotient(dv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seen       <= '0;
      done       <= 1'b0;
      inside_res <= 1'b0;
      for (int i = 0; i < COEF_COUNT; i++) coeff[i] <= '0;
    end else begin
      done <= 1'b0;
      preg <= prod[65:0];
      case (state)
        S_IDLE: begin
          if (start) begin
            kind_r <= kind;
            col    <= column_index;
            ax <= a_x; ay <= a_y; az <= a_z; aw <= a_w;
            bx <= b_x; by <= b_y; bz <= b_z;
            p     <= '0;
            k     <= 2'd3;
            vpass <= 1'b0;
            bsum  <= '0;
            if (kind == KIND_BOX) begin
              cx <= sum_x[32:1]; cy <= sum_y[32:1]; cz <= sum_z[32:1];
            end else begin
              cx <= a_x; cy <= a_y; cz <= a_z;
            end
            sx <= dif_x[32] ? 33'(-dif_x) : dif_x;
            sy <= dif_y[32] ? 33'(-dif_y) : dif_y;
            sz <= dif_z[32] ? 33'(-dif_z) : dif_z;
            rr <= {{2{a_w[31]}}, a_w};
            case (kind)
              KIND_LOAD:   state <= S_LOAD;
              KIND_SPHERE: state <= S_EV_D;
              KIND_BOX:    begin k <= 2'd0; state <= S_BSQ_MUL; end
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          coeff[{p, col}] <= load_val(p, ax, ay, az, aw);
          if (p == 3'(PLANE_COUNT - 1)) begin
            p <= '0;
            k <= '0;
            nsum <= '0;
            if ((seen | (4'd1 << col)) == 4'hF) begin
              seen  <= '0;
              state <= S_NSQ_MUL;
            end else begin
              seen  <= seen | (4'd1 << col);
              state <= S_IDLE;
            end
          end else begin
            p <= p + 3'd1;
          end
        end
        // Normalization: sum of squares, root, then, unless the root is zero, one division per component.
        S_NSQ_MUL: state <= S_NSQ_ACC;
        S_NSQ_ACC: begin
          nsum <= nsum + preg[63:0];
          if (k == 2'd2) begin
            state <= S_NSQ_GO;
          end else begin
            k     <= k + 2'd1;
            state <= S_NSQ_MUL;
          end
        end
        S_NSQ_GO: state <= S_NSQRT;
        S_NSQRT: begin
          if (sq_done) begin
            len <= sq_root;
            k   <= '0;
            if (sq_root == '0) begin
              if (p == 3'(PLANE_COUNT - 1)) begin
                state <= S_IDLE;
              end else begin
                p     <= p + 3'd1;
                nsum  <= '0;
                state <= S_NSQ_MUL;
              end
            end else begin
              state <= S_NDIV;
            end
          end
        end
        S_NDIV: state <= S_NDIV_WAIT;
        S_NDIV_WAIT: begin
          if (dv_done) begin
            coeff[cidx] <= nval;
            if (k == 2'd3) begin
              k <= '0;
              if (p == 3'(PLANE_COUNT - 1)) begin
                state <= S_IDLE;
              end else begin
                p     <= p + 3'd1;
                nsum  <= '0;
                state <= S_NSQ_MUL;
              end
            end else begin
              k     <= k + 2'd1;
              state <= S_NDIV;
            end
          end
        end
        // Box radius from the squared side lengths.
        S_BSQ_MUL: state <= S_BSQ_ACC;
        S_BSQ_ACC: begin
          bsum <= bsum + preg;
          if (k == 2'd2) begin
            state <= S_BSQ_GO;
          end else begin
            k     <= k + 2'd1;
            state <= S_BSQ_MUL;
          end
        end
        S_BSQ_GO: state <= S_BSQRT;
        S_BSQRT: begin
          if (sq_done) begin
            rr    <= {2'b00, sq_root};
            k     <= 2'd3;
            state <= S_EV_D;
          end
        end
        // Plane evaluation: start from d (plus radius), add three products.
        S_EV_D: begin
          acc   <= 64'($signed(cur)) + (vpass ? 64'd0 : 64'($signed(rr)));
          k     <= '0;
          state <= S_EV_MUL;
        end
        S_EV_MUL: state <= S_EV_ACC;
        S_EV_ACC: begin
          acc <= acc + term;
          if (k == 2'd2) begin
            state <= S_EV_CHK;
          end else begin
            k     <= k + 2'd1;
            state <= S_EV_MUL;
          end
        end
        S_EV_CHK: begin
          k <= 2'd3;
          if (fail) begin
            if (!vpass && kind_r == KIND_BOX) begin
              vpass <= 1'b1;
              p     <= '0;
              state <= S_EV_D;
            end else begin
              done       <= 1'b1;
              inside_res <= 1'b0;
              state      <= S_IDLE;
            end
          end else if (p == 3'(PLANE_COUNT - 1)) begin
            done       <= 1'b1;
            inside_res <= 1'b1;
            state      <= S_IDLE;
          end else begin
            p     <= p + 3'd1;
            state <= S_EV_D;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
